// File: hdl/eora_pkg.sv
// eora_pkg: shared constants and types for the encoder outlier-rejecting average
// no dependencies
`default_nettype none

package eora_pkg;

   localparam int SAMPLE_COUNT  = 6;
   localparam int GROWTH_W      = $clog2(SAMPLE_COUNT);
   localparam int KEPT_W        = $clog2(SAMPLE_COUNT + 1);
   localparam int DEF_POS_WIDTH = 24;
   localparam int TRAV_W        = 24;
   localparam int DPI_W         = 15;
   localparam int TARGET_W      = 21;
   localparam int CSR_DATA_W    = 21;
   localparam int CSR_INDEX_W   = 1;
   localparam int QUEUE_DEPTH   = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DPI    = 1'b0,
      CSR_TARGET = 1'b1
   } eora_csr_type;

   typedef logic [SAMPLE_COUNT-1:0] eora_mask_type;

   typedef struct packed {
      logic full;
      logic empty;
   } eora_qstat_type;

endpackage

`default_nettype wire

// File: hdl/encoder_outlier_rejecting_average.sv
// encoder_outlier_rejecting_average: top level, control registers and section wiring
// depends on eora_pkg, eora_front, eora_queue, eora_back
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | six encoder positions, POS_WIDTH bits signed
//   rsp     | out | rsp_valid/rsp_ready  | travelled, reached, outlier_mask, kept_count
//   csr     | in  | csr_we               | csr_index, csr_wdata
//
// one request per cycle sustained while neither the queue nor the response stalls;
// the two bit-per-stage divider pipelines follow an 8-stage classify section
// synchronous reset clears all valids and the queue; degrees_per_inch=1, target=0
// a stalled response freezes the divide section; the 4-entry queue lets the
// classify section keep taking requests until it fills
`default_nettype none

module encoder_outlier_rejecting_average #(
   parameter int POS_WIDTH = eora_pkg::DEF_POS_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [POS_WIDTH-1:0]       req_pos_left_front,
   input  logic signed [POS_WIDTH-1:0]       req_pos_left_middle,
   input  logic signed [POS_WIDTH-1:0]       req_pos_left_back,
   input  logic signed [POS_WIDTH-1:0]       req_pos_right_front,
   input  logic signed [POS_WIDTH-1:0]       req_pos_right_middle,
   input  logic signed [POS_WIDTH-1:0]       req_pos_right_back,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [eora_pkg::TRAV_W-1:0] rsp_travelled,
   output logic                              rsp_reached,
   output eora_pkg::eora_mask_type           rsp_outlier_mask,
   output logic [eora_pkg::KEPT_W-1:0]       rsp_kept_count,
   input  logic                              csr_we,
   input  eora_pkg::eora_csr_type            csr_index,
   input  logic [eora_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import eora_pkg::*;

   localparam int SW = POS_WIDTH + GROWTH_W;
   localparam int QW = SW + KEPT_W + SAMPLE_COUNT;

   logic [DPI_W-1:0]            dpi_ff;
   logic signed [TARGET_W-1:0]  target_ff;

   logic signed [POS_WIDTH-1:0] pos [SAMPLE_COUNT];
   eora_qstat_type              qstat;
   logic                        push, pop;
   logic signed [SW-1:0]        f_kept_sum;
   logic [KEPT_W-1:0]           f_kept;
   eora_mask_type               f_mask;
   logic [QW-1:0]               q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         dpi_ff    <= DPI_W'(1);
         target_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DPI: begin
               dpi_ff <= csr_wdata[DPI_W-1:0];
            end
            CSR_TARGET: begin
               target_ff <= csr_wdata[TARGET_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign pos[0] = req_pos_left_front;
   assign pos[1] = req_pos_left_middle;
   assign pos[2] = req_pos_left_back;
   assign pos[3] = req_pos_right_front;
   assign pos[4] = req_pos_right_middle;
   assign pos[5] = req_pos_right_back;

   eora_front #(
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .pos       (pos),
      .qstat     (qstat),
      .push      (push),
      .kept_sum  (f_kept_sum),
      .kept      (f_kept),
      .mask      (f_mask)
   );

   eora_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  ({f_kept_sum, f_kept, f_mask}),
      .pop    (pop),
      .rdata  (q_rdata),
      .status (qstat)
   );

   eora_back #(
      .POS_WIDTH (POS_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .qstat            (qstat),
      .pop              (pop),
      .kept_sum         ($signed(q_rdata[QW-1 -: SW])),
      .kept             (q_rdata[SAMPLE_COUNT +: KEPT_W]),
      .mask             (q_rdata[SAMPLE_COUNT-1:0]),
      .dpi              (dpi_ff),
      .target           (target_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_travelled    (rsp_travelled),
      .rsp_reached      (rsp_reached),
      .rsp_outlier_mask (rsp_outlier_mask),
      .rsp_kept_count   (rsp_kept_count)
   );

endmodule

`default_nettype wire

// File: hdl/eora_div.sv
// eora_div: pipelined unsigned restoring divider, one quotient bit per stage
// depends on nothing; used by eora_back
`default_nettype none

module eora_div #(
   parameter int NUM_W = 8,
   parameter int DEN_W = 4,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot,
   output logic [TAG_W-1:0] out_tag
);

   logic [NUM_W-1:0] vld_ff;
   logic [NUM_W-1:0] acc_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [TAG_W-1:0] tag_ff [NUM_W];

   logic [NUM_W-1:0] acc_src [NUM_W];
   logic [DEN_W-1:0] rem_src [NUM_W];
   logic [DEN_W-1:0] den_src [NUM_W];
   logic [TAG_W-1:0] tag_src [NUM_W];
   logic [DEN_W:0]   trial   [NUM_W];
   logic             take    [NUM_W];
   logic [NUM_W-1:0] acc_in  [NUM_W];
   logic [DEN_W-1:0] rem_in  [NUM_W];

   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      if (g == 0) begin : g_first
         assign acc_src[g] = in_num;
         assign rem_src[g] = '0;
         assign den_src[g] = in_den;
         assign tag_src[g] = in_tag;
      end else begin : g_next
         assign acc_src[g] = acc_ff[g-1];
         assign rem_src[g] = rem_ff[g-1];
         assign den_src[g] = den_ff[g-1];
         assign tag_src[g] = tag_ff[g-1];
      end

      assign trial[g]  = {rem_src[g], acc_src[g][NUM_W-1]};
      assign take[g]   = trial[g] >= {1'b0, den_src[g]};
      assign rem_in[g] = take[g] ? DEN_W'(trial[g] - {1'b0, den_src[g]})
                                 : trial[g][DEN_W-1:0];
      assign acc_in[g] = {acc_src[g][NUM_W-2:0], take[g]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NUM_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NUM_W; s++) begin
            acc_ff[s] <= acc_in[s];
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_src[s];
            tag_ff[s] <= tag_src[s];
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quot  = acc_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

`default_nettype wire

// File: hdl/eora_front.sv
// eora_front: accepts requests, finds the deviation of each sample and flags outliers
// depends on eora_pkg; feeds eora_queue
`default_nettype none

module eora_front #(
   parameter int POS_WIDTH = eora_pkg::DEF_POS_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [POS_WIDTH-1:0]    pos [eora_pkg::SAMPLE_COUNT],
   input  eora_pkg::eora_qstat_type       qstat,
   output logic                           push,
   output logic signed [POS_WIDTH+eora_pkg::GROWTH_W-1:0] kept_sum,
   output logic [eora_pkg::KEPT_W-1:0]    kept,
   output eora_pkg::eora_mask_type        mask
);

   import eora_pkg::*;

   localparam int SW   = POS_WIDTH + GROWTH_W;
   localparam int DW   = SW + 1;
   localparam int MW   = SW;
   localparam int H    = (MW + 1) / 2;
   localparam int HIW  = MW - H;
   localparam int SQW  = 2 * MW;
   localparam int TOTW = SQW + GROWTH_W;
   localparam int CMPW = TOTW + 2;
   localparam logic signed [DW-1:0] NMUL = DW'(SAMPLE_COUNT);
   localparam logic [CMPW-1:0]      NCMP = CMPW'(SAMPLE_COUNT);

   logic                        en;
   logic [8:1]                  vld_ff;
   logic signed [POS_WIDTH-1:0] xs_ff [1:7][SAMPLE_COUNT];
   logic signed [SW-1:0]        s_ff [2:7];
   logic [MW-1:0]               mag_ff [SAMPLE_COUNT];
   logic [2*H-1:0]              ll_ff [SAMPLE_COUNT];
   logic [MW-1:0]               lh_ff [SAMPLE_COUNT];
   logic [2*HIW-1:0]            hh_ff [SAMPLE_COUNT];
   logic [SQW-1:0]              sq5_ff [SAMPLE_COUNT];
   logic [SQW-1:0]              sq6_ff [SAMPLE_COUNT];
   logic [TOTW-1:0]             tot_ff;
   eora_mask_type               mask7_ff;
   logic signed [SW-1:0]        kept_sum_ff;
   logic [KEPT_W-1:0]           kept_ff;
   eora_mask_type               mask_ff;

   logic signed [SW-1:0]        sum_in;
   logic signed [DW-1:0]        dif [SAMPLE_COUNT];
   logic [MW-1:0]               mag_in [SAMPLE_COUNT];
   logic [2*H-1:0]              ll_in [SAMPLE_COUNT];
   logic [MW-1:0]               lh_in [SAMPLE_COUNT];
   logic [2*HIW-1:0]            hh_in [SAMPLE_COUNT];
   logic [SQW-1:0]              sq_in [SAMPLE_COUNT];
   logic [TOTW-1:0]             tot_in;
   eora_mask_type               mask7_in;
   logic signed [SW-1:0]        ksum;
   logic [KEPT_W-1:0]           kcnt;
   logic signed [SW-1:0]        kept_sum_in;
   logic [KEPT_W-1:0]           kept_in;
   eora_mask_type               mask_in;

   assign en        = !(vld_ff[8] && qstat.full);
   assign req_ready = en;
   assign push      = vld_ff[8] && !qstat.full;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         sum_in = sum_in + SW'(xs_ff[1][i]);
      end
   end

   always_comb begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         dif[i]    = NMUL * DW'(xs_ff[2][i]) - DW'(s_ff[2]);
         mag_in[i] = dif[i][DW-1] ? MW'(-dif[i]) : MW'(dif[i]);
      end
   end

   // square split into half-width partial products
   always_comb begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         ll_in[i] = (2 * H)'(mag_ff[i][H-1:0]) * (2 * H)'(mag_ff[i][H-1:0]);
         lh_in[i] = MW'(mag_ff[i][MW-1:H]) * MW'(mag_ff[i][H-1:0]);
         hh_in[i] = (2 * HIW)'(mag_ff[i][MW-1:H]) * (2 * HIW)'(mag_ff[i][MW-1:H]);
      end
   end

   always_comb begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         sq_in[i] = (SQW'(hh_ff[i]) << (2 * H)) + (SQW'(lh_ff[i]) << (H + 1))
                  + SQW'(ll_ff[i]);
      end
   end

   always_comb begin
      tot_in = '0;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         tot_in = tot_in + TOTW'(sq5_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         mask7_in[i] = (CMPW'(sq6_ff[i]) * NCMP) > (CMPW'(tot_ff) << 2);
      end
   end

   always_comb begin
      ksum = '0;
      kcnt = '0;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         if (!mask7_ff[i]) begin
            ksum = ksum + SW'(xs_ff[7][i]);
            kcnt = kcnt + KEPT_W'(1);
         end
      end
      // guard: nothing kept means keep everything
      if (kcnt == '0) begin
         kept_sum_in = s_ff[7];
         kept_in     = KEPT_W'(SAMPLE_COUNT);
         mask_in     = '0;
      end else begin
         kept_sum_in = ksum;
         kept_in     = kcnt;
         mask_in     = mask7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[7:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xs_ff[1] <= pos;
         for (int k = 2; k <= 7; k++) begin
            xs_ff[k] <= xs_ff[k-1];
         end
         s_ff[2] <= sum_in;
         for (int k = 3; k <= 7; k++) begin
            s_ff[k] <= s_ff[k-1];
         end
         mag_ff      <= mag_in;
         ll_ff       <= ll_in;
         lh_ff       <= lh_in;
         hh_ff       <= hh_in;
         sq5_ff      <= sq_in;
         sq6_ff      <= sq5_ff;
         tot_ff      <= tot_in;
         mask7_ff    <= mask7_in;
         kept_sum_ff <= kept_sum_in;
         kept_ff     <= kept_in;
         mask_ff     <= mask_in;
      end
   end

   assign kept_sum = kept_sum_ff;
   assign kept     = kept_ff;
   assign mask     = mask_ff;

   a_kept_matches_mask: assert property (@(posedge clock) disable iff (reset)
      vld_ff[8] |-> ($countones(mask_ff) + int'(kept_ff)) == SAMPLE_COUNT)
      else $error("kept count disagrees with outlier mask");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[8] && qstat.full) |=> (vld_ff[8] && $stable(kept_sum_ff) && $stable(mask_ff)))
      else $error("front result lost while queue full");

endmodule

`default_nettype wire

// File: hdl/eora_queue.sv
// eora_queue: short register fifo between the classify and divide sections
// depends on eora_pkg
`default_nettype none

module eora_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = eora_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     pop,
   output logic [WIDTH-1:0]         rdata,
   output eora_pkg::eora_qstat_type status
);

   import eora_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW-1:0]    wr_ptr_in, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
   assign rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata        = mem_ff[rd_ptr_ff];
   assign status.full  = count_ff == CW'(DEPTH);
   assign status.empty = count_ff == '0;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: hdl/eora_back.sv
// eora_back: mean of kept samples, scale by degrees per inch, saturate and compare
// depends on eora_pkg and eora_div; drains eora_queue
`default_nettype none

module eora_back #(
   parameter int POS_WIDTH = eora_pkg::DEF_POS_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  eora_pkg::eora_qstat_type       qstat,
   output logic                           pop,
   input  logic signed [POS_WIDTH+eora_pkg::GROWTH_W-1:0] kept_sum,
   input  logic [eora_pkg::KEPT_W-1:0]    kept,
   input  eora_pkg::eora_mask_type        mask,
   input  logic [eora_pkg::DPI_W-1:0]     dpi,
   input  logic signed [eora_pkg::TARGET_W-1:0] target,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [eora_pkg::TRAV_W-1:0] rsp_travelled,
   output logic                           rsp_reached,
   output eora_pkg::eora_mask_type        rsp_outlier_mask,
   output logic [eora_pkg::KEPT_W-1:0]    rsp_kept_count
);

   import eora_pkg::*;

   localparam int SW   = POS_WIDTH + GROWTH_W;
   localparam int TAGW = 1 + SAMPLE_COUNT + KEPT_W;
   localparam int TVW  = (POS_WIDTH + 1 > TRAV_W) ? POS_WIDTH + 1 : TRAV_W;
   localparam logic signed [TVW-1:0] SAT_MAX = TVW'((2 ** (TRAV_W - 1)) - 1);
   localparam logic signed [TVW-1:0] SAT_MIN = TVW'(-(2 ** (TRAV_W - 1)));

   logic                      en;
   logic                      vld0_ff;
   logic                      neg0_ff;
   logic [SW-1:0]             mag0_ff;
   logic [KEPT_W-1:0]         kept0_ff;
   eora_mask_type             mask0_ff;
   logic [SW-1:0]             mag0_in;

   logic                      v1, v2;
   logic [SW-1:0]             q1;
   logic [POS_WIDTH-1:0]      q2;
   logic [TAGW-1:0]           tag1, tag2;
   logic [DPI_W-1:0]          dpi_eff;

   logic signed [POS_WIDTH:0] q2_s;
   logic signed [POS_WIDTH:0] trav;
   logic signed [TVW-1:0]     trav_x;
   logic signed [TVW-1:0]     sat;
   logic signed [TRAV_W-1:0]  tgt_x;
   logic signed [TRAV_W-1:0]  travelled_in;

   logic                      rsp_valid_ff;
   logic signed [TRAV_W-1:0]  travelled_ff;
   logic                      reached_ff;
   eora_mask_type             mask_ff;
   logic [KEPT_W-1:0]         kept_ff;

   // whole section advances unless a response is stalled
   assign en  = !rsp_valid_ff || rsp_ready;
   assign pop = en && !qstat.empty;

   assign mag0_in = kept_sum[SW-1] ? SW'(-kept_sum) : SW'(kept_sum);
   assign dpi_eff = (dpi == '0) ? DPI_W'(1) : dpi;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg0_ff  <= kept_sum[SW-1];
         mag0_ff  <= mag0_in;
         kept0_ff <= kept;
         mask0_ff <= mask;
      end
   end

   eora_div #(
      .NUM_W (SW),
      .DEN_W (KEPT_W),
      .TAG_W (TAGW)
   ) u_mean_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld0_ff),
      .in_num    (mag0_ff),
      .in_den    (kept0_ff),
      .in_tag    ({neg0_ff, mask0_ff, kept0_ff}),
      .out_valid (v1),
      .out_quot  (q1),
      .out_tag   (tag1)
   );

   eora_div #(
      .NUM_W (POS_WIDTH),
      .DEN_W (DPI_W),
      .TAG_W (TAGW)
   ) u_scale_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1),
      .in_num    (q1[POS_WIDTH-1:0]),
      .in_den    (dpi_eff),
      .in_tag    (tag1),
      .out_valid (v2),
      .out_quot  (q2),
      .out_tag   (tag2)
   );

   // sign goes back on after both magnitude divisions, so both truncate toward zero
   assign q2_s   = {1'b0, q2};
   assign trav   = tag2[TAGW-1] ? -q2_s : q2_s;
   assign trav_x = TVW'(trav);

   always_comb begin
      if (trav_x > SAT_MAX) begin
         sat = SAT_MAX;
      end else if (trav_x < SAT_MIN) begin
         sat = SAT_MIN;
      end else begin
         sat = trav_x;
      end
   end

   assign travelled_in = sat[TRAV_W-1:0];
   assign tgt_x        = TRAV_W'(target);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         travelled_ff <= travelled_in;
         reached_ff   <= travelled_in >= tgt_x;
         mask_ff      <= tag2[KEPT_W +: SAMPLE_COUNT];
         kept_ff      <= tag2[KEPT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_travelled    = travelled_ff;
   assign rsp_reached      = reached_ff;
   assign rsp_outlier_mask = mask_ff;
   assign rsp_kept_count   = kept_ff;

endmodule

`default_nettype wire
